FILE: rtl/scrs_pkg.sv
// ---------------------------------------------------------------------------
// Stepped clock rate sequencer package
// Shared types, result codes and the operating point ROM.
// ---------------------------------------------------------------------------
package scrs_pkg;

	localparam int KHZ_W       = 21;
	localparam int PT_W        = 4;
	localparam int ROM_ROWS    = 9;
	localparam logic [PT_W-1:0] RESET_POINT = 4'd1;

	// Configuration register indexes.
	localparam logic REG_MAX_STEP   = 1'b0;
	localparam logic REG_ONLINE_MSK = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_CORE_STEP = 2'd0;
	localparam logic [1:0] KIND_L2_CHANGE = 2'd1;
	localparam logic [1:0] KIND_STATUS    = 2'd2;

	// Clock unit for the L2 clock.
	localparam logic [1:0] UNIT_L2 = 2'd2;

	// Switch actions.
	localparam logic [1:0] ACT_REMUX    = 2'd0;
	localparam logic [1:0] ACT_PLL_ON   = 2'd1;
	localparam logic [1:0] ACT_PLL_OFF  = 2'd2;
	localparam logic [1:0] ACT_PLL_SLEW = 2'd3;

	// Status codes.
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_UNCHANGED = 2'd1;
	localparam logic [1:0] STAT_BAD_CORE  = 2'd2;
	localparam logic [1:0] STAT_UNKNOWN   = 2'd3;

	// One row of the operating point table.
	typedef struct packed {
		logic [KHZ_W-1:0] khz;
		logic             on_pll;
		logic [1:0]       src_sel;
		logic [1:0]       src_div;
		logic [1:0]       core_src;
		logic [5:0]       l_val;
		logic [1:0]       l2_src;
		logic [5:0]       l2_l;
	} op_point_t;

	// One result item as it leaves the sequencer.
	typedef struct packed {
		logic [1:0]      result_kind;
		logic [1:0]      clock_unit;
		logic [1:0]      switch_action;
		logic [PT_W-1:0] point_index;
		logic [5:0]      pll_multiplier;
		logic [1:0]      mux_source;
		logic [1:0]      mux_divider;
		logic [1:0]      core_source;
		logic [1:0]      status;
		logic            last;
	} result_t;

	// Flags from the shared difference unit.
	typedef struct packed {
		logic eq;
		logic in_step;
	} cmp_t;

	// Operating point ROM; rows past the table read as zero.
	function automatic op_point_t rom_row(input logic [PT_W-1:0] idx);
		op_point_t r;
		r = '0;
		unique case (idx)
			4'd0: r = '{khz: 21'd192000, on_pll: 1'b0, src_sel: 2'd3, src_div: 2'd1,
				core_src: 2'd0, l_val: 6'h00, l2_src: 2'd0, l2_l: 6'h00};
			4'd1: r = '{khz: 21'd262000, on_pll: 1'b0, src_sel: 2'd1, src_div: 2'd0,
				core_src: 2'd0, l_val: 6'h00, l2_src: 2'd0, l2_l: 6'h00};
			4'd2: r = '{khz: 21'd384000, on_pll: 1'b0, src_sel: 2'd3, src_div: 2'd0,
				core_src: 2'd0, l_val: 6'h00, l2_src: 2'd0, l2_l: 6'h00};
			4'd3: r = '{khz: 21'd432000, on_pll: 1'b1, src_sel: 2'd0, src_div: 2'd0,
				core_src: 2'd1, l_val: 6'h08, l2_src: 2'd1, l2_l: 6'h08};
			4'd4: r = '{khz: 21'd648000, on_pll: 1'b1, src_sel: 2'd0, src_div: 2'd0,
				core_src: 2'd1, l_val: 6'h0C, l2_src: 2'd1, l2_l: 6'h0C};
			4'd5: r = '{khz: 21'd810000, on_pll: 1'b1, src_sel: 2'd0, src_div: 2'd0,
				core_src: 2'd1, l_val: 6'h0F, l2_src: 2'd1, l2_l: 6'h0F};
			4'd6: r = '{khz: 21'd972000, on_pll: 1'b1, src_sel: 2'd0, src_div: 2'd0,
				core_src: 2'd1, l_val: 6'h12, l2_src: 2'd1, l2_l: 6'h10};
			4'd7: r = '{khz: 21'd1080000, on_pll: 1'b1, src_sel: 2'd0, src_div: 2'd0,
				core_src: 2'd1, l_val: 6'h14, l2_src: 2'd1, l2_l: 6'h10};
			4'd8: r = '{khz: 21'd1188000, on_pll: 1'b1, src_sel: 2'd0, src_div: 2'd0,
				core_src: 2'd1, l_val: 6'h16, l2_src: 2'd1, l2_l: 6'h10};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/stepped_clock_rate_sequencer_core.sv
// ---------------------------------------------------------------------------
// Stepped clock rate sequencer, top level
// Turns a core rate request into a sequence of clock switch actions.
// ---------------------------------------------------------------------------
// A request enters on the s_ channel (core index and target rate in kHz).
// The block checks the core, compares the rate with the core's present
// point, scans the operating point table one row per cycle, then walks
// toward the target. Each walk step and any L2 clock change leaves on the
// m_ channel as one result; m_tlast marks the final result of a request.
// The walk and the table scan use one shared subtract-and-compare unit,
// which does every table check in turn. Each walk step compares the
// target with the present point; when the target is out of step range,
// a scan picks the farthest row within the step limit, or the next row
// when none lies within it. An invalid core, an unchanged rate or an
// unknown rate gives a single status result. s_tready is low while a
// request is in work. A finished result waits in the output register,
// so a stalled receiver holds the sequencer only when it has the next
// result ready. Reset puts both cores, their L2 votes and the L2 clock
// at the fabric point (table row 1), max_step_khz at 1188000 and both
// cores online. Configuration writes take effect on the next edge.
// ---------------------------------------------------------------------------
module stepped_clock_rate_sequencer_core #(
	parameter int TABLE_ENTRIES = 9,
	parameter int CORE_COUNT    = 2
) (
	input  logic        clk,
	input  logic        arst_n,

	// Request channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // core_index[1:0], rate_khz[22:2]

	// Result channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // clock_unit[1:0], switch_action[3:2],
	                               // point_index[7:4], pll_multiplier[13:8],
	                               // mux_source[15:14], mux_divider[17:16],
	                               // core_source[19:18], status[21:20]
	output logic [1:0]  m_tuser,   // result_kind[1:0]
	output logic        m_tlast,

	// Configuration write port.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [20:0] cfg_wdata
);

	logic [scrs_pkg::KHZ_W-1:0] max_step_q;
	logic [1:0]                 online_mask_q;
	logic                       m_tvalid_q;
	scrs_pkg::result_t          res_q;
	logic                       out_free;
	logic                       seq_idle;
	logic                       emit_valid;
	scrs_pkg::result_t          emit;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q    <= 21'd1188000;
			online_mask_q <= 2'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				scrs_pkg::REG_MAX_STEP:   max_step_q    <= cfg_wdata;
				scrs_pkg::REG_ONLINE_MSK: online_mask_q <= cfg_wdata[1:0];
				default:                  max_step_q    <= max_step_q;
			endcase
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = seq_idle;

	scrs_sequencer #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.CORE_COUNT    (CORE_COUNT)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (s_tvalid && seq_idle),
		.in_core     (s_tdata[1:0]),
		.in_rate     (s_tdata[22:2]),
		.max_step    (max_step_q),
		.online_mask (online_mask_q),
		.out_free    (out_free),
		.idle        (seq_idle),
		.emit_valid  (emit_valid),
		.emit        (emit)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid) begin
			res_q <= emit;
		end
	end

	// Pack the result onto the channel.
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, res_q.status, res_q.core_source, res_q.mux_divider,
		res_q.mux_source, res_q.pll_multiplier, res_q.point_index,
		res_q.switch_action, res_q.clock_unit};
	assign m_tuser  = res_q.result_kind;
	assign m_tlast  = res_q.last;

endmodule

FILE: rtl/scrs_diff_unit.sv
// ---------------------------------------------------------------------------
// Shared difference unit
// One subtractor that serves every rate match and every step-size check.
// ---------------------------------------------------------------------------
module scrs_diff_unit (
	input  logic [scrs_pkg::KHZ_W-1:0] hi_khz,
	input  logic [scrs_pkg::KHZ_W-1:0] lo_khz,
	input  logic [scrs_pkg::KHZ_W-1:0] max_step,
	output scrs_pkg::cmp_t             flags
);

	logic [scrs_pkg::KHZ_W:0] diff;

	// The extra top bit is the borrow; a borrow means hi is below lo.
	assign diff = {1'b0, hi_khz} - {1'b0, lo_khz};

	assign flags.eq      = (diff == '0);
	assign flags.in_step = !diff[scrs_pkg::KHZ_W] && (diff[scrs_pkg::KHZ_W-1:0] <= max_step);

endmodule

FILE: rtl/scrs_sequencer.sv
// ---------------------------------------------------------------------------
// Rate walk sequencer
// Checks a request, scans the table, walks the steps and settles the L2 vote.
// ---------------------------------------------------------------------------
module scrs_sequencer #(
	parameter int TABLE_ENTRIES = 9,
	parameter int CORE_COUNT    = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  in_core,
	input  logic [scrs_pkg::KHZ_W-1:0]  in_rate,
	input  logic [scrs_pkg::KHZ_W-1:0]  max_step,
	input  logic [1:0]                  online_mask,
	input  logic                        out_free,
	output logic                        idle,
	output logic                        emit_valid,
	output scrs_pkg::result_t           emit
);

	localparam int USABLE = (TABLE_ENTRIES > scrs_pkg::ROM_ROWS) ? scrs_pkg::ROM_ROWS :
		((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
	localparam logic [scrs_pkg::PT_W-1:0] LAST_ROW = scrs_pkg::PT_W'(USABLE - 1);
	localparam logic [1:0] CORE_LIMIT = 2'(CORE_COUNT);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CHECK  = 4'd1;
	localparam logic [3:0] ST_LOOKUP = 4'd2;
	localparam logic [3:0] ST_L2EVAL = 4'd3;
	localparam logic [3:0] ST_DIST   = 4'd4;
	localparam logic [3:0] ST_SCAN   = 4'd5;
	localparam logic [3:0] ST_EMIT   = 4'd6;
	localparam logic [3:0] ST_L2EMIT = 4'd7;
	localparam logic [3:0] ST_STATUS = 4'd8;

	logic [3:0]                   state_q;
	logic [scrs_pkg::PT_W-1:0]    core_point_q [2];
	logic [scrs_pkg::PT_W-1:0]    vote_q [2];
	logic [scrs_pkg::PT_W-1:0]    l2_point_q;

	logic [1:0]                   core_q;
	logic [scrs_pkg::KHZ_W-1:0]   rate_q;
	logic [scrs_pkg::PT_W-1:0]    cur_q;
	logic [scrs_pkg::PT_W-1:0]    tgt_q;
	logic [scrs_pkg::PT_W-1:0]    j_q;
	logic [scrs_pkg::PT_W-1:0]    nxt_q;
	logic [scrs_pkg::PT_W-1:0]    best_q;
	logic                         up_q;
	logic                         l2chg_q;
	logic [1:0]                   status_q;

	scrs_pkg::op_point_t          row_cur, row_tgt, row_j, row_nxt, row_best, row_l2, row_at;
	scrs_pkg::op_point_t          row_v0, row_v1, row_zero;
	logic [scrs_pkg::PT_W-1:0]    cur_sel;
	logic [scrs_pkg::PT_W-1:0]    vote0, vote1, best_c;
	logic [5:0]                   best_l;
	logic                         l2chg_c;
	logic                         up_now;
	logic [scrs_pkg::PT_W-1:0]    first_nb;
	logic                         scan_end;
	logic [scrs_pkg::KHZ_W-1:0]   hi_khz, lo_khz;
	scrs_pkg::cmp_t               flags;
	scrs_pkg::result_t            step_res, l2_res, stat_res;

	// Table reads for the points in play.
	assign cur_sel  = core_point_q[core_q[0]];
	assign row_at   = scrs_pkg::rom_row(cur_sel);
	assign row_cur  = scrs_pkg::rom_row(cur_q);
	assign row_tgt  = scrs_pkg::rom_row(tgt_q);
	assign row_j    = scrs_pkg::rom_row(j_q);
	assign row_nxt  = scrs_pkg::rom_row(nxt_q);
	assign row_best = scrs_pkg::rom_row(best_q);
	assign row_l2   = scrs_pkg::rom_row(l2_point_q);

	// Direction of the remaining walk and the first neighbor in that direction.
	assign up_now   = (tgt_q > cur_q);
	assign first_nb = up_now ? (cur_q + 1'b1) : (cur_q - 1'b1);
	assign scan_end = up_q ? (j_q == LAST_ROW) : (j_q == '0);

	// Operand selection for the shared difference unit.
	always_comb begin
		hi_khz = rate_q;
		lo_khz = row_j.khz;
		case (state_q)
			ST_CHECK: begin
				hi_khz = rate_q;
				lo_khz = row_at.khz;
			end
			ST_DIST: begin
				hi_khz = up_now ? row_tgt.khz : row_cur.khz;
				lo_khz = up_now ? row_cur.khz : row_tgt.khz;
			end
			ST_SCAN: begin
				hi_khz = up_q ? row_j.khz : row_cur.khz;
				lo_khz = up_q ? row_cur.khz : row_j.khz;
			end
			default: begin
				hi_khz = rate_q;
				lo_khz = row_j.khz;
			end
		endcase
	end

	scrs_diff_unit u_diff (
		.hi_khz   (hi_khz),
		.lo_khz   (lo_khz),
		.max_step (max_step),
		.flags    (flags)
	);

	// Highest L2 vote among online cores, with this core's vote set to the target.
	always_comb begin
		vote0    = (core_q[0] == 1'b0) ? tgt_q : vote_q[0];
		vote1    = (core_q[0] == 1'b1) ? tgt_q : vote_q[1];
		row_v0   = scrs_pkg::rom_row(vote0);
		row_v1   = scrs_pkg::rom_row(vote1);
		row_zero = scrs_pkg::rom_row('0);
		best_c   = '0;
		best_l   = row_zero.l2_l;
		if (online_mask[0] && (row_v0.l2_l > best_l)) begin
			best_c = vote0;
			best_l = row_v0.l2_l;
		end
		if ((CORE_COUNT > 1) && online_mask[1] && (row_v1.l2_l > best_l)) begin
			best_c = vote1;
			best_l = row_v1.l2_l;
		end
		l2chg_c = (best_l != row_l2.l2_l);
	end

	// Core step result from the current and next points.
	always_comb begin
		step_res             = '0;
		step_res.result_kind = scrs_pkg::KIND_CORE_STEP;
		step_res.clock_unit  = core_q;
		step_res.point_index = nxt_q;
		step_res.core_source = row_nxt.core_src;
		step_res.status      = scrs_pkg::STAT_OK;
		step_res.last        = (nxt_q == tgt_q) && !l2chg_q;
		if (!row_cur.on_pll && !row_nxt.on_pll) begin
			step_res.switch_action = scrs_pkg::ACT_REMUX;
			step_res.mux_source    = row_nxt.src_sel;
			step_res.mux_divider   = row_nxt.src_div;
		end else if (!row_cur.on_pll) begin
			step_res.switch_action  = scrs_pkg::ACT_PLL_ON;
			step_res.pll_multiplier = row_nxt.l_val;
		end else if (!row_nxt.on_pll) begin
			step_res.switch_action = scrs_pkg::ACT_PLL_OFF;
			step_res.mux_source    = row_nxt.src_sel;
			step_res.mux_divider   = row_nxt.src_div;
		end else begin
			step_res.switch_action  = scrs_pkg::ACT_PLL_SLEW;
			step_res.pll_multiplier = row_nxt.l_val;
		end
	end

	// L2 clock change result.
	always_comb begin
		l2_res             = '0;
		l2_res.result_kind = scrs_pkg::KIND_L2_CHANGE;
		l2_res.clock_unit  = scrs_pkg::UNIT_L2;
		l2_res.point_index = best_q;
		l2_res.core_source = row_best.l2_src;
		l2_res.status      = scrs_pkg::STAT_OK;
		l2_res.last        = 1'b1;
		if ((row_l2.l2_src == 2'd1) && (row_best.l2_src == 2'd1)) begin
			l2_res.switch_action  = scrs_pkg::ACT_PLL_SLEW;
			l2_res.pll_multiplier = row_best.l2_l;
		end else if (row_best.l2_src == 2'd1) begin
			l2_res.switch_action  = scrs_pkg::ACT_PLL_ON;
			l2_res.pll_multiplier = row_best.l2_l;
		end else begin
			l2_res.switch_action = scrs_pkg::ACT_PLL_OFF;
		end
	end

	// Status-only result.
	always_comb begin
		stat_res             = '0;
		stat_res.result_kind = scrs_pkg::KIND_STATUS;
		stat_res.status      = status_q;
		stat_res.last        = 1'b1;
	end

	// Result handed to the output register.
	always_comb begin
		emit       = stat_res;
		emit_valid = 1'b0;
		case (state_q)
			ST_EMIT: begin
				emit       = step_res;
				emit_valid = out_free;
			end
			ST_L2EMIT: begin
				emit       = l2_res;
				emit_valid = out_free;
			end
			ST_STATUS: begin
				emit       = stat_res;
				emit_valid = out_free;
			end
			default: begin
				emit       = stat_res;
				emit_valid = 1'b0;
			end
		endcase
	end

	assign idle = (state_q == ST_IDLE);

	// Sequencer and the per-core and L2 clock state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			core_point_q[0] <= scrs_pkg::RESET_POINT;
			core_point_q[1] <= scrs_pkg::RESET_POINT;
			vote_q[0]       <= scrs_pkg::RESET_POINT;
			vote_q[1]       <= scrs_pkg::RESET_POINT;
			l2_point_q      <= scrs_pkg::RESET_POINT;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (core_q >= CORE_LIMIT) begin
						state_q <= ST_STATUS;
					end else if (flags.eq) begin
						state_q <= ST_STATUS;
					end else begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (flags.eq) begin
						state_q <= ST_L2EVAL;
					end else if (j_q == LAST_ROW) begin
						state_q <= ST_STATUS;
					end
				end
				ST_L2EVAL: begin
					vote_q[core_q[0]] <= tgt_q;
					state_q           <= ST_DIST;
				end
				ST_DIST: begin
					state_q <= flags.in_step ? ST_EMIT : ST_SCAN;
				end
				ST_SCAN: begin
					if (!flags.in_step || scan_end) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						core_point_q[core_q[0]] <= nxt_q;
						if (nxt_q == tgt_q) begin
							state_q <= l2chg_q ? ST_L2EMIT : ST_IDLE;
						end else begin
							state_q <= ST_DIST;
						end
					end
				end
				ST_L2EMIT: begin
					if (out_free) begin
						l2_point_q <= best_q;
						state_q    <= ST_IDLE;
					end
				end
				ST_STATUS: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the request in progress.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					core_q <= in_core;
					rate_q <= in_rate;
				end
			end
			ST_CHECK: begin
				cur_q <= cur_sel;
				j_q   <= '0;
				if (core_q >= CORE_LIMIT) begin
					status_q <= scrs_pkg::STAT_BAD_CORE;
				end else begin
					status_q <= scrs_pkg::STAT_UNCHANGED;
				end
			end
			ST_LOOKUP: begin
				tgt_q    <= j_q;
				j_q      <= j_q + 1'b1;
				status_q <= scrs_pkg::STAT_UNKNOWN;
			end
			ST_L2EVAL: begin
				best_q  <= best_c;
				l2chg_q <= l2chg_c;
			end
			ST_DIST: begin
				up_q  <= up_now;
				j_q   <= first_nb;
				nxt_q <= flags.in_step ? tgt_q : first_nb;
			end
			ST_SCAN: begin
				if (flags.in_step) begin
					nxt_q <= j_q;
					j_q   <= up_q ? (j_q + 1'b1) : (j_q - 1'b1);
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cur_q <= nxt_q;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

endmodule

FILE: tb/stepped_clock_rate_sequencer_core_test.sv
// ---------------------------------------------------------------------------
// Stepped clock rate sequencer testbench
// Drives rate requests and configuration writes into the sequencer and
// checks every switch step, L2 clock change and status result it returns
// against a behavioral predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module stepped_clock_rate_sequencer_core_test;

	localparam int CORES          = 2;
	localparam int ROWS           = 9;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 40;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_REQUESTS = 38;

	// Receiver stall behaviors.
	typedef enum int {RX_FREE, RX_RANDOM, RX_BURSTY, RX_ALTERNATE} rx_mode_t;

	// Predicts the switch sequence of each request and holds it until the
	// sequencer delivers it.
	class switch_sequence_board;
		int point_khz [ROWS];
		int on_pll [ROWS];
		int src_sel [ROWS];
		int src_div [ROWS];
		int core_src [ROWS];
		int l_val [ROWS];
		int l2_src [ROWS];
		int l2_l [ROWS];
		int max_step;
		logic [1:0] online_mask;
		logic [3:0] core_pt [CORES];
		logic [3:0] vote_pt [CORES];
		logic [3:0] l2_pt;
		scrs_pkg::result_t expected [$];
		int errors;
		int requests;
		int core_steps;
		int l2_changes;
		int status_results;

		function new();
			point_khz = '{192000, 262000, 384000, 432000, 648000, 810000, 972000, 1080000,
				1188000};
			on_pll   = '{0, 0, 0, 1, 1, 1, 1, 1, 1};
			src_sel  = '{3, 1, 3, 0, 0, 0, 0, 0, 0};
			src_div  = '{1, 0, 0, 0, 0, 0, 0, 0, 0};
			core_src = '{0, 0, 0, 1, 1, 1, 1, 1, 1};
			l_val    = '{'h00, 'h00, 'h00, 'h08, 'h0C, 'h0F, 'h12, 'h14, 'h16};
			l2_src   = '{0, 0, 0, 1, 1, 1, 1, 1, 1};
			l2_l     = '{'h00, 'h00, 'h00, 'h08, 'h0C, 'h0F, 'h10, 'h10, 'h10};
			max_step = 1188000;
			online_mask = 2'b11;
			for (int c = 0; c < CORES; c++) begin
				core_pt[c] = scrs_pkg::RESET_POINT;
				vote_pt[c] = scrs_pkg::RESET_POINT;
			end
			l2_pt = scrs_pkg::RESET_POINT;
		endfunction

		function void set_regs(int step, logic [1:0] mask);
			max_step = step;
			online_mask = mask;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// Works out every result of one accepted request and updates the state.
		function void note_request(logic [1:0] core, logic [20:0] rate);
			scrs_pkg::result_t seq [16];
			scrs_pkg::result_t r;
			logic [1:0] verdict;
			int n, tgt, cur, nxt, best, lc, d;
			n = 0;
			tgt = -1;
			requests++;
			verdict = scrs_pkg::STAT_OK;
			if (int'(core) >= CORES)
				verdict = scrs_pkg::STAT_BAD_CORE;
			else if (int'(rate) == point_khz[core_pt[core]])
				verdict = scrs_pkg::STAT_UNCHANGED;
			else begin
				for (int i = 0; i < ROWS; i++)
					if (tgt < 0 && point_khz[i] == int'(rate)) tgt = i;
				if (tgt < 0) verdict = scrs_pkg::STAT_UNKNOWN;
			end

			if (verdict != scrs_pkg::STAT_OK) begin
				r = '0;
				r.result_kind = scrs_pkg::KIND_STATUS;
				r.status = verdict;
				seq[0] = r;
				n = 1;
				status_results++;
			end else begin
				// Walk toward the target, taking the farthest row within the step
				// limit, or one row when none lies within it.
				cur = int'(core_pt[core]);
				while (cur != tgt && n < 15) begin
					d = (point_khz[cur] > point_khz[tgt]) ? point_khz[cur] - point_khz[tgt]
						: point_khz[tgt] - point_khz[cur];
					if (d <= max_step)
						nxt = tgt;
					else if (tgt > cur) begin
						nxt = cur + 1;
						for (int j = cur + 1; j < ROWS; j++) begin
							if (point_khz[j] - point_khz[cur] > max_step) break;
							nxt = j;
						end
					end else begin
						nxt = cur - 1;
						for (int j = cur - 1; j >= 0; j--) begin
							if (point_khz[cur] - point_khz[j] > max_step) break;
							nxt = j;
						end
					end
					r = '0;
					r.result_kind = scrs_pkg::KIND_CORE_STEP;
					r.clock_unit = core;
					r.point_index = nxt[3:0];
					r.core_source = 2'(core_src[nxt]);
					if (on_pll[cur] == 0 && on_pll[nxt] == 0) begin
						r.switch_action = scrs_pkg::ACT_REMUX;
						r.mux_source = 2'(src_sel[nxt]);
						r.mux_divider = 2'(src_div[nxt]);
					end else if (on_pll[cur] == 0) begin
						r.switch_action = scrs_pkg::ACT_PLL_ON;
						r.pll_multiplier = 6'(l_val[nxt]);
					end else if (on_pll[nxt] == 0) begin
						r.switch_action = scrs_pkg::ACT_PLL_OFF;
						r.mux_source = 2'(src_sel[nxt]);
						r.mux_divider = 2'(src_div[nxt]);
					end else begin
						r.switch_action = scrs_pkg::ACT_PLL_SLEW;
						r.pll_multiplier = 6'(l_val[nxt]);
					end
					seq[n] = r;
					n++;
					core_steps++;
					cur = nxt;
				end
				core_pt[core] = cur[3:0];
				vote_pt[core] = tgt[3:0];

				// The L2 clock follows the highest vote among the online cores.
				best = 0;
				for (int c = 0; c < CORES; c++)
					if (online_mask[c] && l2_l[vote_pt[c]] > l2_l[best]) best = int'(vote_pt[c]);
				lc = int'(l2_pt);
				if (l2_l[best] != l2_l[lc]) begin
					r = '0;
					r.result_kind = scrs_pkg::KIND_L2_CHANGE;
					r.clock_unit = scrs_pkg::UNIT_L2;
					r.point_index = best[3:0];
					r.core_source = 2'(l2_src[best]);
					if (l2_src[lc] == 1 && l2_src[best] == 1) begin
						r.switch_action = scrs_pkg::ACT_PLL_SLEW;
						r.pll_multiplier = 6'(l2_l[best]);
					end else if (l2_src[best] == 1) begin
						r.switch_action = scrs_pkg::ACT_PLL_ON;
						r.pll_multiplier = 6'(l2_l[best]);
					end else
						r.switch_action = scrs_pkg::ACT_PLL_OFF;
					seq[n] = r;
					n++;
					l2_changes++;
					l2_pt = best[3:0];
				end
			end

			seq[n - 1].last = 1'b1;
			for (int i = 0; i < n; i++)
				expected.push_back(seq[i]);
		endfunction

		function void field(string name, int want, int seen);
			if (want != seen) begin
				$display("%0t ERROR %s mismatch: expected %0d, actual %0d", $time, name,
					want, seen);
				errors++;
			end
		endfunction

		// Compares one delivered result with the oldest outstanding one.
		function void check_result(scrs_pkg::result_t seen);
			scrs_pkg::result_t want;
			if (expected.size() == 0) begin
				$display("%0t ERROR result with none expected: actual %p", $time, seen);
				errors++;
				return;
			end
			want = expected.pop_front();
			field("result_kind", int'(want.result_kind), int'(seen.result_kind));
			field("clock_unit", int'(want.clock_unit), int'(seen.clock_unit));
			field("switch_action", int'(want.switch_action), int'(seen.switch_action));
			field("point_index", int'(want.point_index), int'(seen.point_index));
			field("pll_multiplier", int'(want.pll_multiplier), int'(seen.pll_multiplier));
			field("mux_source", int'(want.mux_source), int'(seen.mux_source));
			field("mux_divider", int'(want.mux_divider), int'(seen.mux_divider));
			field("core_source", int'(want.core_source), int'(seen.core_source));
			field("status", int'(want.status), int'(seen.status));
			field("last", int'(want.last), int'(seen.last));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // core_index[1:0], rate_khz[22:2]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // clock_unit[1:0], switch_action[3:2], point_index[7:4],
	                        // pll_multiplier[13:8], mux_source[15:14],
	                        // mux_divider[17:16], core_source[19:18], status[21:20]
	logic [1:0]  m_tuser;   // result_kind[1:0]
	logic        m_tlast;
	logic        cfg_we;
	logic        cfg_index;
	logic [20:0] cfg_wdata;

	switch_sequence_board sb;
	int burst_left;
	int idle_cycles;
	int settings;

	stepped_clock_rate_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Sends one request; the sender pauses between bursts of random length.
	task automatic issue(input logic [1:0] core, input logic [20:0] rate);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 10);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, rate, core};
		do @(posedge clk); while (!s_tready);
		sb.note_request(core, rate);
	endtask

	// Holds the sender off until every outstanding result has arrived.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		@(posedge clk);
	endtask

	// Writes both registers back to back while the sequencer is idle.
	task automatic program_regs(input int step, input logic [1:0] mask);
		cfg_we <= 1'b1;
		cfg_index <= scrs_pkg::REG_MAX_STEP;
		cfg_wdata <= step[20:0];
		@(posedge clk);
		cfg_index <= scrs_pkg::REG_ONLINE_MSK;
		cfg_wdata <= {19'd0, mask};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_regs(step, mask);
		settings++;
	endtask

	// Receiver readiness: free running, random, long stalls or alternating.
	initial begin
		rx_mode_t mode;
		int stall_left;
		int phase;
		mode = RX_FREE;
		stall_left = 0;
		phase = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			phase++;
			if (phase % 97 == 0) mode = rx_mode_t'($urandom_range(0, 3));
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					RX_FREE: begin
						m_tready <= 1'b1;
					end
					RX_RANDOM: begin
						m_tready <= ($urandom_range(0, 3) != 0);
					end
					RX_BURSTY: begin
						if ($urandom_range(0, 15) == 0) begin
							stall_left = $urandom_range(5, 25);
							m_tready <= 1'b0;
						end else
							m_tready <= 1'b1;
					end
					default: begin
						m_tready <= phase[0];
					end
				endcase
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin : result_monitor
		scrs_pkg::result_t observed;
		if (arst_n && m_tvalid && m_tready) begin
			observed.result_kind    = m_tuser;
			observed.clock_unit     = m_tdata[1:0];
			observed.switch_action  = m_tdata[3:2];
			observed.point_index    = m_tdata[7:4];
			observed.pll_multiplier = m_tdata[13:8];
			observed.mux_source     = m_tdata[15:14];
			observed.mux_divider    = m_tdata[17:16];
			observed.core_source    = m_tdata[19:18];
			observed.status         = m_tdata[21:20];
			observed.last           = m_tlast;
			sb.check_result(observed);
		end
	end

	// Watchdog on cycles in which neither channel moves a request or result.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("%0t ERROR watchdog expired with %0d results outstanding", $time,
			sb.pending());
		$display("tb: failure");
		$finish;
	end

	// Main sequence: reset, directed requests, then random phases.
	initial begin
		int sel;
		int step;
		logic [1:0] core;
		logic [20:0] rate;
		idle_cycles = 0;
		burst_left = 0;
		settings = 0;
		sb = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= scrs_pkg::REG_MAX_STEP;
		cfg_wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rejected cores, an unchanged rate and unknown rates.
		issue(2'd2, 21'd262000);
		issue(2'd3, 21'd2097151);
		issue(2'd0, 21'd262000);
		issue(2'd1, 21'd0);
		issue(2'd0, 21'd2097151);
		issue(2'd0, 21'd262001);
		// Single jumps at the reset step limit: PLL enable, L2 enable, slew.
		issue(2'd0, 21'd1188000);
		issue(2'd1, 21'd972000);
		issue(2'd1, 21'd1080000);
		// Zero step limit: the walk moves one row at a time down to the bottom.
		drain();
		program_regs(0, 2'b11);
		issue(2'd0, 21'd192000);
		issue(2'd1, 21'd192000);
		// Widest step limit, with an L2 slew up.
		drain();
		program_regs(2097151, 2'b11);
		issue(2'd0, 21'd648000);
		issue(2'd1, 21'd810000);
		// Step limit equal to a table gap, only core 0 voting.
		drain();
		program_regs(108000, 2'b01);
		issue(2'd1, 21'd384000);
		issue(2'd0, 21'd1188000);
		// Only core 1 voting: remux steps and L2 enable and disable.
		drain();
		program_regs(1188000, 2'b10);
		issue(2'd0, 21'd192000);
		issue(2'd0, 21'd384000);
		issue(2'd1, 21'd432000);
		issue(2'd1, 21'd384000);
		issue(2'd1, 21'd384000);

		// Random phases, each under a fresh register setting.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			case ($urandom_range(0, 5))
				0: step = 0;
				1: step = 2097151;
				2: step = $urandom_range(1, 200000);
				3: step = $urandom_range(0, 2097151);
				4: step = 108000;
				default: step = 1188000;
			endcase
			program_regs(step, 2'($urandom_range(1, 3)));
			for (int k = 0; k < PHASE_REQUESTS; k++) begin
				if ($urandom_range(0, 39) == 0) drain();
				sel = $urandom_range(0, 99);
				core = 2'($urandom_range(0, CORES - 1));
				rate = 21'(sb.point_khz[$urandom_range(0, ROWS - 1)]);
				if (sel < 8)
					rate = 21'(sb.point_khz[sb.core_pt[core]]);
				else if (sel < 16) begin
					core = 2'($urandom_range(2, 3));
					if ($urandom_range(0, 1) == 0) rate = 21'($urandom_range(0, 2097151));
				end else if (sel < 24)
					rate = 21'($urandom_range(0, 2097151));
				else if (sel < 28)
					rate = ($urandom_range(0, 1) == 0) ? rate + 21'd1 : rate - 21'd1;
				issue(core, rate);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d requests under %0d register settings.", sb.requests,
			settings);
		$display("Predicted %0d core steps, %0d L2 changes and %0d status results.",
			sb.core_steps, sb.l2_changes, sb.status_results);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
